>>> rtl/pps_pkg.sv
// Shared types, constants and helper functions of the projection profile segmenter.
package pps_pkg;

	// Fixed field geometry
	localparam int PIXEL_FIELDS = 8;
	localparam int FIELD_MAX = 4095;
	localparam logic [7:0] THRESHOLD_RESET = 8'd128;
	localparam logic [11:0] RUNS_MAX = 12'hFFF;

	typedef logic [7:0] pix_t;
	typedef logic [11:0] field_t;
	typedef logic [3:0] lane_cnt_t;

	// Lane findings plus framing flags of one beat in stage 1
	typedef struct packed {
		logic [PIXEL_FIELDS-1:0] dark;
		logic                    group_end;
		logic                    image_end;
	} beat_s1_t;

	// One result beat
	typedef struct packed {
		field_t      group_number;
		field_t      dark_total;
		logic        segment_valid;
		field_t      segment_start;
		logic [12:0] segment_length;
		field_t      segment_index;
		logic        image_done;
	} result_t;

	// Count set dark flags across all lanes
	function automatic lane_cnt_t popcount(input logic [PIXEL_FIELDS-1:0] bits);
		lane_cnt_t n;
		n = '0;
		for (int i = 0; i < PIXEL_FIELDS; i++) begin
			n = n + lane_cnt_t'(bits[i]);
		end
		return n;
	endfunction

endpackage

>>> rtl/pps_lane.sv
// One pixel lane: threshold compare with a registered dark flag.
module pps_lane (
	input  logic          clk,
	input  logic          load,
	input  logic          enable,
	input  pps_pkg::pix_t pixel,
	input  pps_pkg::pix_t threshold,
	output logic          dark_s1
);
	import pps_pkg::*;

	// Capture dark flag on an accepted beat
	always_ff @(posedge clk) begin
		if (load) begin
			dark_s1 <= enable && (pixel < threshold);
		end
	end

endmodule

>>> rtl/pps_merge.sv
// Merge stage: sums lane flags, tracks group and run state, holds the result register.
module pps_merge #(
	parameter int DARK_CAP = 4095,
	parameter int GROUP_CAP = 4095
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s1_valid,
	input  pps_pkg::beat_s1_t s1_beat,
	output logic              s1_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output pps_pkg::result_t  res
);
	import pps_pkg::*;

	localparam field_t DARK_CAP_W = field_t'(DARK_CAP);
	localparam field_t GROUP_CAP_W = field_t'(GROUP_CAP);

	field_t group_dark_acc_q;
	field_t group_counter_q;
	logic   run_active_q;
	field_t run_first_q;
	field_t runs_closed_q;
	logic   out_valid_q;
	result_t res_q;

	lane_cnt_t   cnt;
	logic [12:0] sum;
	field_t      acc_new;
	logic        ends;
	logic        occupied;
	logic        active_eff;
	field_t      first_eff;
	logic        close;
	logic [12:0] seg_len;
	logic        fire;
	result_t     res_d;

	// Merge lane flags into the open group and decide run closing
	always_comb begin
		cnt = popcount(s1_beat.dark);
		sum = {1'b0, group_dark_acc_q} + 13'(cnt);
		acc_new = (sum > {1'b0, DARK_CAP_W}) ? DARK_CAP_W : sum[11:0];
		ends = s1_beat.group_end | s1_beat.image_end;
		occupied = (acc_new != '0);
		active_eff = run_active_q | occupied;
		first_eff = run_active_q ? run_first_q : group_counter_q;
		close = active_eff && (!occupied || s1_beat.image_end);
		seg_len = {1'b0, group_counter_q} - {1'b0, first_eff} + 13'(occupied);

		res_d.group_number = group_counter_q;
		res_d.dark_total = acc_new;
		res_d.segment_valid = close;
		res_d.segment_start = close ? first_eff : '0;
		res_d.segment_length = close ? seg_len : '0;
		res_d.segment_index = close ? runs_closed_q : '0;
		res_d.image_done = s1_beat.image_end;
	end

	// Stall only a result-bearing beat behind a held result
	assign s1_ready = !(ends && out_valid_q && out_stall);
	assign fire = s1_valid && s1_ready;

	// Advance group and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_dark_acc_q <= '0;
			group_counter_q <= '0;
			run_active_q <= 1'b0;
			run_first_q <= '0;
			runs_closed_q <= '0;
		end else if (fire) begin
			if (!ends) begin
				group_dark_acc_q <= acc_new;
			end else if (s1_beat.image_end) begin
				group_dark_acc_q <= '0;
				group_counter_q <= '0;
				run_active_q <= 1'b0;
				run_first_q <= '0;
				runs_closed_q <= '0;
			end else begin
				group_dark_acc_q <= '0;
				if (group_counter_q < GROUP_CAP_W) begin
					group_counter_q <= group_counter_q + 12'd1;
				end
				run_active_q <= active_eff && !close;
				run_first_q <= first_eff;
				if (close && (runs_closed_q != RUNS_MAX)) begin
					runs_closed_q <= runs_closed_q + 12'd1;
				end
			end
		end
	end

	// Output valid: set on a result beat, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ends) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (fire && ends) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

endmodule

>>> rtl/projection_profile_segmenter.sv
// Top level of the projection profile segmenter: lanes, stage-1 register and merge.
// A group-ending beat's result passes the stage-1 register, then the result register,
// on its way to the outputs.
// Throughput: one beat per cycle unless a group-ending beat waits behind a stalled result;
// the lane compares and the merge popcount-add each take one stage.
// A beat that ends no group passes even while a result waits at the output.
// Reset clears all counters and run state and sets dark_threshold to 128.
module projection_profile_segmenter #(
	parameter int LANES = 8,
	parameter int MAX_GROUPS = 4096,
	parameter int MAX_GROUP_LEN = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pixel_0,
	input  logic [7:0]  pixel_1,
	input  logic [7:0]  pixel_2,
	input  logic [7:0]  pixel_3,
	input  logic [7:0]  pixel_4,
	input  logic [7:0]  pixel_5,
	input  logic [7:0]  pixel_6,
	input  logic [7:0]  pixel_7,
	input  logic [3:0]  lanes_valid,
	input  logic        group_end,
	input  logic        image_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] group_number,
	output logic [11:0] dark_total,
	output logic        segment_valid,
	output logic [11:0] segment_start,
	output logic [12:0] segment_length,
	output logic [11:0] segment_index,
	output logic        image_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  dark_threshold
);
	import pps_pkg::*;

	localparam int NLANE = (LANES < PIXEL_FIELDS) ? LANES : PIXEL_FIELDS;
	localparam int DARK_CAP = (MAX_GROUP_LEN < FIELD_MAX) ? MAX_GROUP_LEN : FIELD_MAX;
	localparam int GROUP_CAP = ((MAX_GROUPS - 1) < FIELD_MAX) ? (MAX_GROUPS - 1) : FIELD_MAX;

	pix_t                    pix [PIXEL_FIELDS];
	pix_t                    thr_q;
	logic                    load;
	logic                    s1_valid_s1;
	logic                    s1_ready;
	logic [PIXEL_FIELDS-1:0] dark_s1;
	logic                    group_end_s1;
	logic                    image_end_s1;
	beat_s1_t                beat_s1;
	result_t                 res;

	assign pix[0] = pixel_0;
	assign pix[1] = pixel_1;
	assign pix[2] = pixel_2;
	assign pix[3] = pixel_3;
	assign pix[4] = pixel_4;
	assign pix[5] = pixel_5;
	assign pix[6] = pixel_6;
	assign pix[7] = pixel_7;

	// Threshold register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_valid) begin
			thr_q <= dark_threshold;
		end
	end

	// Hold stage 1 only when its beat cannot move on
	assign in_stall = s1_valid_s1 && !s1_ready;
	assign load = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			group_end_s1 <= group_end;
			image_end_s1 <= image_end;
		end
	end

	// Pixel lanes
	for (genvar i = 0; i < PIXEL_FIELDS; i++) begin : g_lane
		if (i < NLANE) begin : g_used
			pps_lane u_lane (
				.clk       (clk),
				.load      (load),
				.enable    (lanes_valid > 4'(i)),
				.pixel     (pix[i]),
				.threshold (thr_q),
				.dark_s1   (dark_s1[i])
			);
		end else begin : g_off
			assign dark_s1[i] = 1'b0;
		end
	end

	assign beat_s1 = {dark_s1, group_end_s1, image_end_s1};

	pps_merge #(
		.DARK_CAP  (DARK_CAP),
		.GROUP_CAP (GROUP_CAP)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid_s1),
		.s1_beat   (beat_s1),
		.s1_ready  (s1_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign group_number = res.group_number;
	assign dark_total = res.dark_total;
	assign segment_valid = res.segment_valid;
	assign segment_start = res.segment_start;
	assign segment_length = res.segment_length;
	assign segment_index = res.segment_index;
	assign image_done = res.image_done;

endmodule

>>> rtl/pps_checker.sv
// Port-level checker for the projection profile segmenter, bound to the top level.
module pps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] group_number,
	input logic [11:0] dark_total,
	input logic        segment_valid,
	input logic [11:0] segment_start,
	input logic [12:0] segment_length,
	input logic [11:0] segment_index,
	input logic        image_done
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(group_number) && $stable(dark_total))
		else $error("result beat changed while stalled");

	// Without a closed run the segment fields read zero
	a_seg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !segment_valid |->
			segment_start == 12'd0 && segment_length == 13'd0 && segment_index == 12'd0)
		else $error("segment fields set without a closed run");

	// A closed run never starts after the group that closes it
	a_seg_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segment_valid |-> segment_start <= group_number)
		else $error("segment start beyond current group");

	// Inside an image a run closes only on an empty group
	a_seg_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segment_valid && !image_done |-> dark_total == 12'd0)
		else $error("run closed on an occupied group");

endmodule

bind projection_profile_segmenter pps_checker u_pps_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the projection profile segmenter.
`timescale 1ns / 1ps

module tb;
	import pps_pkg::*;

	localparam int LANES = 8;
	localparam int MAX_GROUPS = 4096;
	localparam int MAX_GROUP_LEN = 4096;
	localparam int LANE_CAP = (LANES < PIXEL_FIELDS) ? LANES : PIXEL_FIELDS;
	localparam int DARK_CAP = (MAX_GROUP_LEN < FIELD_MAX) ? MAX_GROUP_LEN : FIELD_MAX;
	localparam int GROUP_CAP = (MAX_GROUPS - 1 < FIELD_MAX) ? MAX_GROUPS - 1 : FIELD_MAX;
	localparam int RANDOM_BEATS = 480;
	localparam int PHASES = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	// One input beat; lane 0 sits in the low byte
	typedef struct packed {
		logic [7:0][7:0] pix;
		lane_cnt_t       lanes;
		logic            gend;
		logic            iend;
	} beat_t;

	// Directed row: beat plus an optional hand-written result
	typedef struct packed {
		beat_t   beat;
		logic    typed;
		result_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel_0 = '0;
	logic [7:0]  pixel_1 = '0;
	logic [7:0]  pixel_2 = '0;
	logic [7:0]  pixel_3 = '0;
	logic [7:0]  pixel_4 = '0;
	logic [7:0]  pixel_5 = '0;
	logic [7:0]  pixel_6 = '0;
	logic [7:0]  pixel_7 = '0;
	logic [3:0]  lanes_valid = 4'd1;
	logic        group_end = 1'b0;
	logic        image_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [11:0] group_number;
	logic [11:0] dark_total;
	logic        segment_valid;
	logic [11:0] segment_start;
	logic [12:0] segment_length;
	logic [11:0] segment_index;
	logic        image_done;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  dark_threshold = THRESHOLD_RESET;

	// Predictor state
	logic [7:0] dark_level = THRESHOLD_RESET;
	int         dark_acc = 0;
	int         group_idx = 0;
	bit         run_open = 1'b0;
	int         run_first = 0;
	int         runs_closed = 0;

	result_t pending_profiles [$];
	int      mismatches = 0;
	int      quiet_cycles = 0;
	int      beats_sent = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;

	row_t directed_plan [13] = '{
		'{'{64'h0000000000000000, 4'd8, 1'b1, 1'b0}, 1'b1,
			'{12'd0, 12'd8, 1'b0, 12'd0, 13'd0, 12'd0, 1'b0}},
		'{'{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1'b0}, 1'b1,
			'{12'd1, 12'd0, 1'b1, 12'd0, 13'd1, 12'd0, 1'b0}},
		'{'{64'h7F7F7F7F7F7F7F7F, 4'd8, 1'b0, 1'b0}, 1'b0, '0},
		'{'{64'h8080808080808080, 4'd8, 1'b1, 1'b0}, 1'b0, '0},
		'{'{64'h0000000000000000, 4'd0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{64'h0000000000000000, 4'd15, 1'b1, 1'b0}, 1'b0, '0},
		'{'{64'h0000000000000000, 4'd9, 1'b0, 1'b0}, 1'b0, '0},
		'{'{64'h0000000000000000, 4'd1, 1'b0, 1'b1}, 1'b0, '0},
		'{'{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1'b0}, 1'b1,
			'{12'd0, 12'd0, 1'b0, 12'd0, 13'd0, 12'd0, 1'b0}},
		'{'{64'hC864FE01807FFF00, 4'd8, 1'b1, 1'b0}, 1'b0, '0},
		'{'{64'hC864FE01807FFF00, 4'd3, 1'b1, 1'b1}, 1'b0, '0},
		'{'{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0, 1'b1}, 1'b1,
			'{12'd0, 12'd0, 1'b0, 12'd0, 13'd0, 12'd0, 1'b1}},
		'{'{64'h0000000000000000, 4'd8, 1'b1, 1'b1}, 1'b1,
			'{12'd0, 12'd8, 1'b1, 12'd0, 13'd1, 12'd0, 1'b1}}
	};

	projection_profile_segmenter #(
		.LANES(LANES),
		.MAX_GROUPS(MAX_GROUPS),
		.MAX_GROUP_LEN(MAX_GROUP_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_0(pixel_0),
		.pixel_1(pixel_1),
		.pixel_2(pixel_2),
		.pixel_3(pixel_3),
		.pixel_4(pixel_4),
		.pixel_5(pixel_5),
		.pixel_6(pixel_6),
		.pixel_7(pixel_7),
		.lanes_valid(lanes_valid),
		.group_end(group_end),
		.image_end(image_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.group_number(group_number),
		.dark_total(dark_total),
		.segment_valid(segment_valid),
		.segment_start(segment_start),
		.segment_length(segment_length),
		.segment_index(segment_index),
		.image_done(image_done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.dark_threshold(dark_threshold)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the projection state by one beat; return 1 when a group result is due
	function automatic bit project_beat(input beat_t b, output result_t r);
		int  n;
		int  idx;
		bit  occ;
		r = '0;
		n = (b.lanes > LANE_CAP) ? LANE_CAP : b.lanes;
		for (int i = 0; i < n; i++) begin
			if (b.pix[i] < dark_level && dark_acc < DARK_CAP)
				dark_acc++;
		end
		if (!b.gend && !b.iend)
			return 1'b0;
		idx = group_idx;
		occ = (dark_acc != 0);
		if (occ && !run_open) begin
			run_open = 1'b1;
			run_first = idx;
		end
		// Close the run on an empty group or at image end
		if (run_open && (!occ || b.iend)) begin
			r.segment_valid = 1'b1;
			r.segment_start = 12'(run_first);
			r.segment_length = 13'(idx - run_first + int'(occ));
			r.segment_index = 12'(runs_closed);
			if (runs_closed < FIELD_MAX)
				runs_closed++;
			run_open = 1'b0;
		end
		r.group_number = 12'(idx);
		r.dark_total = 12'(dark_acc);
		r.image_done = b.iend;
		dark_acc = 0;
		if (b.iend) begin
			group_idx = 0;
			run_first = 0;
			runs_closed = 0;
		end else if (group_idx < GROUP_CAP) begin
			group_idx++;
		end
		return 1'b1;
	endfunction

	// Drive one beat, hold it until accepted, then record what it should produce
	task automatic push_beat(input beat_t b, input bit typed, input result_t want);
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_0 <= b.pix[0];
		pixel_1 <= b.pix[1];
		pixel_2 <= b.pix[2];
		pixel_3 <= b.pix[3];
		pixel_4 <= b.pix[4];
		pixel_5 <= b.pix[5];
		pixel_6 <= b.pix[6];
		pixel_7 <= b.pix[7];
		lanes_valid <= b.lanes;
		group_end <= b.gend;
		image_end <= b.iend;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		if (project_beat(b, r))
			pending_profiles.push_back(typed ? want : r);
	endtask

	// Drop valid and wait until every expected result is out and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_profiles.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] level);
		cfg_valid <= 1'b1;
		dark_threshold <= level;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		dark_level = level;
	endtask

	function automatic logic [7:0] pick_pixel(input bit dark);
		if (dark && dark_level != 0)
			return 8'($urandom_range(dark_level - 1, 0));
		return 8'($urandom_range(255, dark_level));
	endfunction

	function automatic beat_t plain_beat(input logic [7:0] level, input bit gend, input bit iend);
		beat_t b;
		b.pix = {8{level}};
		b.lanes = 4'd8;
		b.gend = gend;
		b.iend = iend;
		return b;
	endfunction

	// Saturate the dark count in one long group, then close the run and the image
	task automatic push_saturation_image();
		for (int k = 0; k < 512; k++)
			push_beat(plain_beat(8'h00, k == 511, 1'b0), k == 511,
				'{12'd0, 12'd4095, 1'b0, 12'd0, 13'd0, 12'd0, 1'b0});
		push_beat(plain_beat(8'hFF, 1'b1, 1'b0), 1'b0, '0);
		push_beat(plain_beat(8'h00, 1'b1, 1'b1), 1'b0, '0);
	endtask

	// Send one image of occupied and empty groups, with some noise beats mixed in
	task automatic push_random_image();
		int    groups;
		int    len;
		bit    occ;
		beat_t b;
		groups = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
		for (int g = 0; g < groups; g++) begin
			occ = 1'($urandom_range(1));
			len = $urandom_range(3, 1);
			for (int k = 0; k < len; k++) begin
				for (int i = 0; i < 8; i++)
					b.pix[i] = pick_pixel(occ && $urandom_range(99) < 40);
				b.lanes = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
					4'($urandom_range(8, 1));
				b.gend = (k == len - 1);
				b.iend = (g == groups - 1) && (k == len - 1);
				if (b.iend)
					b.gend = 1'($urandom_range(1));
				if ($urandom_range(19) == 0) begin
					b.pix = {$urandom, $urandom};
					b.lanes = 4'($urandom_range(15));
					b.gend = 1'($urandom_range(1));
					b.iend = 1'($urandom_range(1));
				end
				push_beat(b, 1'b0, '0);
			end
		end
	endtask

	// Stall the result side at the current rate
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_profiles.size() == 0) begin
				$error("result beat with no expected result");
				mismatches++;
			end else begin
				want = pending_profiles.pop_front();
				if (group_number !== want.group_number) begin
					$error("group_number: expected %0d, got %0d", want.group_number, group_number);
					mismatches++;
				end
				if (dark_total !== want.dark_total) begin
					$error("dark_total: expected %0d, got %0d", want.dark_total, dark_total);
					mismatches++;
				end
				if (segment_valid !== want.segment_valid) begin
					$error("segment_valid: expected %0d, got %0d", want.segment_valid,
						segment_valid);
					mismatches++;
				end
				if (segment_start !== want.segment_start) begin
					$error("segment_start: expected %0d, got %0d", want.segment_start,
						segment_start);
					mismatches++;
				end
				if (segment_length !== want.segment_length) begin
					$error("segment_length: expected %0d, got %0d", want.segment_length,
						segment_length);
					mismatches++;
				end
				if (segment_index !== want.segment_index) begin
					$error("segment_index: expected %0d, got %0d", want.segment_index,
						segment_index);
					mismatches++;
				end
				if (image_done !== want.image_done) begin
					$error("image_done: expected %0d, got %0d", want.image_done, image_done);
					mismatches++;
				end
			end
		end
	end

	// End the run when no beat moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int          idle_mode [4] = '{0, 65, 0, 37};
		int          stall_mode [4] = '{0, 0, 65, 37};
		logic [7:0]  phase_level [PHASES];
		phase_level = '{8'd0, 8'd255, 8'd1, 8'd254, 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), THRESHOLD_RESET};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset threshold
		foreach (directed_plan[i])
			push_beat(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);
		push_saturation_image();
		drain();

		// Random images under each threshold and idling mix
		for (int p = 0; p < PHASES; p++) begin
			idle_pct = idle_mode[p % 4];
			stall_pct = stall_mode[p % 4];
			write_threshold(phase_level[p]);
			beats_sent = 0;
			while (beats_sent < RANDOM_BEATS / PHASES)
				push_random_image();
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
